// ----- design/wrtd_pkg.sv -----
// ----------------------------------------------------------------------------
// wrtd_pkg
// Shared types and constants of the weighted table draw block: request and
// response payloads, status codes, opcodes and default sizes.
// ----------------------------------------------------------------------------
package wrtd_pkg;

	localparam int GROUPS_DEF = 16;
	localparam int SLOTS_DEF  = 8;

	localparam int GROUP_W  = 4;
	localparam int KIND_W   = 4;
	localparam int CODE_W   = 16;
	localparam int WEIGHT_W = 16;
	localparam int RAND_W   = 31;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef enum logic [1:0] {
		ST_LOADED = 2'd0,
		ST_DRAWN  = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic                opcode;
		logic [GROUP_W-1:0]  group;
		logic [KIND_W-1:0]   entry_kind;
		logic [CODE_W-1:0]   entry_code;
		logic [WEIGHT_W-1:0] weight;
		logic [RAND_W-1:0]   random_value;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [KIND_W-1:0] drawn_kind;
		logic [CODE_W-1:0] drawn_code;
	} rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [CODE_W-1:0]   code;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

endpackage

// ----- design/wrtd_req_if.sv -----
// ----------------------------------------------------------------------------
// wrtd_req_if
// Request channel: valid/ready handshake carrying one load or draw request.
// ----------------------------------------------------------------------------
interface wrtd_req_if;
	import wrtd_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- design/wrtd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wrtd_rsp_if
// Response channel: valid/ready handshake carrying one status and entry.
// ----------------------------------------------------------------------------
interface wrtd_rsp_if;
	import wrtd_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- design/weighted_random_table_draw.sv -----
// Flow: a load or an empty-group draw answers straight after the count lookup, a
// zero-weight draw after summing n entries, any other draw after the sum, the
// remainder and a scan of k entries: one entry memory read per cycle for sum and
// scan, one remainder bit per cycle. One request in work at a time; the next can be
// taken in the cycle after the response register loads. Reset clears the group
// valid bits (all counts read as zero) and the control.
// ----------------------------------------------------------------------------
// weighted_random_table_draw
// Per-group weighted entry lists held in synchronous memory, with append and
// roulette-wheel draw by a sequencer.
// ----------------------------------------------------------------------------
module weighted_random_table_draw #(
	parameter int GROUPS = wrtd_pkg::GROUPS_DEF,
	parameter int SLOTS  = wrtd_pkg::SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	wrtd_req_if.sink   req,
	wrtd_rsp_if.source rsp
);
	import wrtd_pkg::*;

	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int DEPTH = GROUPS * SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = WEIGHT_W + ((SLOTS > 1) ? $clog2(SLOTS) : 0);
	localparam int MW    = $clog2(RAND_W);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CNT  = 6'b000010,
		S_SUM  = 6'b000100,
		S_MOD  = 6'b001000,
		S_SCAN = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	// memories
	entry_t          ent_mem [DEPTH];
	logic [CW-1:0]   cnt_mem [GROUPS];
	entry_t          ent_rd_q;
	logic [CW-1:0]   cnt_rd_q;
	logic [GROUPS-1:0] valid_q;

	state_t          state_q, state_d;
	logic            op_q;
	logic [GROUP_W-1:0] group_q;
	logic [KIND_W-1:0]  kind_q;
	logic [CODE_W-1:0]  code_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [RAND_W-1:0]  rnd_q;
	logic [CW-1:0]   n_q;
	logic [SW-1:0]   slot_q;
	logic [TW-1:0]   total_q;
	logic [TW-1:0]   rem_q;
	logic [TW-1:0]   cum_q;
	logic [MW-1:0]   mod_cnt_q;
	rsp_t            res_q;
	rsp_t            out_q;
	logic            out_valid_q;

	logic            req_take;
	logic            out_free;
	logic [GW-1:0]   grp_idx;
	logic [GW-1:0]   req_idx;
	logic            in_range;
	logic [CW-1:0]   cnt_cur;
	logic            load_ok;
	logic [AW-1:0]   base;
	logic [SW-1:0]   rd_slot;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [TW-1:0]   total_sum;
	logic [TW:0]     rem_shift;
	logic            rem_ge;
	logic [TW-1:0]   cum_sum;
	logic            last_slot;

	assign req_take  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign out_free  = !out_valid_q || rsp.ready;

	assign req_idx   = GW'(req.data.group);
	assign grp_idx   = GW'(group_q);
	assign in_range  = (32'(group_q) < GROUPS);
	assign cnt_cur   = valid_q[grp_idx] ? cnt_rd_q : '0;
	assign load_ok   = in_range && (32'(cnt_cur) < SLOTS);
	assign base      = AW'(32'(grp_idx) * SLOTS);
	assign rd_slot   = (state_q == S_SUM || state_q == S_SCAN) ? slot_q + SW'(1) : '0;
	assign rd_addr   = base + AW'(rd_slot);
	assign wr_addr   = base + AW'(cnt_cur);
	assign total_sum = total_q + TW'(ent_rd_q.weight);
	assign rem_shift = {rem_q, rnd_q[RAND_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, total_q});
	assign cum_sum   = cum_q + TW'(ent_rd_q.weight);
	assign last_slot = (CW'(slot_q) == n_q - CW'(1));

	// memory ports
	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[req_idx];
		ent_rd_q <= ent_mem[rd_addr];
		if (state_q == S_CNT && op_q == OP_LOAD && load_ok) begin
			cnt_mem[grp_idx] <= cnt_cur + CW'(1);
			ent_mem[wr_addr] <= '{kind: kind_q, code: code_q, weight: weight_q};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_take) state_d = S_CNT;
			S_CNT: begin
				if (op_q == OP_LOAD || !in_range || cnt_cur == '0) state_d = S_DONE;
				else state_d = S_SUM;
			end
			S_SUM: begin
				if (last_slot) state_d = (total_sum == '0) ? S_DONE : S_MOD;
			end
			S_MOD: if (mod_cnt_q == '0) state_d = S_SCAN;
			S_SCAN: begin
				if (rem_q < cum_sum || last_slot) state_d = S_DONE;
			end
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			if (state_q == S_CNT && op_q == OP_LOAD && load_ok) valid_q[grp_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					op_q     <= req.data.opcode;
					group_q  <= req.data.group;
					kind_q   <= req.data.entry_kind;
					code_q   <= req.data.entry_code;
					weight_q <= req.data.weight;
					rnd_q    <= req.data.random_value;
				end
			end
			S_CNT: begin
				res_q   <= '{status: (op_q == OP_LOAD) ? (load_ok ? ST_LOADED : ST_FULL)
						: ST_EMPTY, drawn_kind: '0, drawn_code: '0};
				n_q     <= cnt_cur;
				slot_q  <= '0;
				total_q <= '0;
			end
			S_SUM: begin
				total_q   <= total_sum;
				slot_q    <= slot_q + SW'(1);
				rem_q     <= '0;
				mod_cnt_q <= MW'(RAND_W - 1);
			end
			S_MOD: begin
				rem_q     <= rem_ge ? TW'(rem_shift - {1'b0, total_q}) : rem_shift[TW-1:0];
				rnd_q     <= rnd_q << 1;
				mod_cnt_q <= mod_cnt_q - MW'(1);
				slot_q    <= '0;
				cum_q     <= '0;
			end
			S_SCAN: begin
				cum_q  <= cum_sum;
				slot_q <= slot_q + SW'(1);
				if (rem_q < cum_sum) begin
					res_q <= '{status: ST_DRAWN, drawn_kind: ent_rd_q.kind,
						drawn_code: ent_rd_q.code};
				end
			end
			S_DONE: if (out_free) out_q <= res_q;
			default: ;
		endcase
	end

	// checks
	a_take_to_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q == S_CNT)
		else $error("request taken without count lookup");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOD |-> rem_q < total_q)
		else $error("remainder not below total");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CW'(slot_q) < n_q)
		else $error("scan beyond group count");

	a_drawn_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.status == ST_DRAWN) |-> op_q == OP_DRAW)
		else $error("draw status on a load");

	a_out_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside completion");

endmodule

// ----- tb/tb_weighted_random_table_draw.sv -----
// ----------------------------------------------------------------------------
// tb_weighted_random_table_draw
// Drives load and draw requests into the weighted table draw block. A shadow
// copy of the group lists predicts each response, and responses are compared
// in order. Directed cases come first, then random traffic under several
// idling mixes, a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_weighted_random_table_draw;
	import wrtd_pkg::*;

	localparam int NUM_GROUPS     = GROUPS_DEF;
	localparam int NUM_SLOTS      = SLOTS_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 80;

	logic clk = 1'b0;
	logic arst_n;

	wrtd_req_if req_ch();
	wrtd_rsp_if rsp_ch();

	weighted_random_table_draw uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow of the group lists
	logic [WEIGHT_W-1:0] shadow_weight [NUM_GROUPS][NUM_SLOTS];
	logic [KIND_W-1:0]   shadow_kind   [NUM_GROUPS][NUM_SLOTS];
	logic [CODE_W-1:0]   shadow_code   [NUM_GROUPS][NUM_SLOTS];
	int                  shadow_fill   [NUM_GROUPS];

	rsp_t awaited_outcomes [$];
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	int   send_idle_pct = 0;
	int   rsp_stall_pct = 0;
	bit   hold_requested = 1'b0;
	int   hold_left = 0;

	function automatic rsp_t roulette_outcome(input req_t r);
		rsp_t        o;
		int          g;
		logic [31:0] total;
		logic [31:0] reduced;
		logic [31:0] running;
		bit          found;
		o.status = ST_EMPTY;
		o.drawn_kind = '0;
		o.drawn_code = '0;
		g = r.group;
		if (r.opcode == OP_LOAD) begin
			if (g >= NUM_GROUPS || shadow_fill[g] >= NUM_SLOTS) begin
				o.status = ST_FULL;
			end else begin
				shadow_weight[g][shadow_fill[g]] = r.weight;
				shadow_kind[g][shadow_fill[g]] = r.entry_kind;
				shadow_code[g][shadow_fill[g]] = r.entry_code;
				shadow_fill[g]++;
				o.status = ST_LOADED;
			end
		end else if (g < NUM_GROUPS && shadow_fill[g] != 0) begin
			total = '0;
			for (int s = 0; s < shadow_fill[g]; s++)
				total = total + 32'(shadow_weight[g][s]);
			if (total != 0) begin
				reduced = {1'b0, r.random_value} % total;
				running = '0;
				found = 1'b0;
				for (int s = 0; s < shadow_fill[g]; s++) begin
					if (!found && reduced < running + 32'(shadow_weight[g][s])) begin
						found = 1'b1;
						o.status = ST_DRAWN;
						o.drawn_kind = shadow_kind[g][s];
						o.drawn_code = shadow_code[g][s];
					end
					running = running + 32'(shadow_weight[g][s]);
				end
			end
		end
		return o;
	endfunction

	function automatic req_t make_request(input logic op, input int g, input int kind,
			input int code, input int w, input logic [RAND_W-1:0] rnd);
		req_t r;
		r.opcode = op;
		r.group = GROUP_W'(g);
		r.entry_kind = KIND_W'(kind);
		r.entry_code = CODE_W'(code);
		r.weight = WEIGHT_W'(w);
		r.random_value = rnd;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		r.opcode = ($urandom_range(99) < 40) ? OP_LOAD : OP_DRAW;
		r.group = GROUP_W'($urandom_range(NUM_GROUPS - 1));
		r.entry_kind = KIND_W'($urandom);
		r.entry_code = CODE_W'($urandom);
		pick = $urandom_range(9);
		case (pick)
		0: begin
			r.weight = '0;
		end
		1, 2, 3, 4: begin
			r.weight = WEIGHT_W'($urandom_range(4, 1));
		end
		5: begin
			r.weight = '1;
		end
		default: begin
			r.weight = WEIGHT_W'($urandom);
		end
		endcase
		pick = $urandom_range(3);
		if (pick == 0)
			r.random_value = RAND_W'($urandom_range(300));
		else if (pick == 1)
			r.random_value = {RAND_W{1'b1}} - RAND_W'($urandom_range(300));
		else
			r.random_value = RAND_W'($urandom);
		return r;
	endfunction

	// offers one request, returns in the step it is taken
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		awaited_outcomes.insert(awaited_outcomes.size(), roulette_outcome(r));
	endtask

	task automatic test_empty_group();
		send_request(make_request(OP_DRAW, 1, 0, 0, 0, '0));
		send_request(make_request(OP_LOAD, 2, 3, 16'h0003, 0, '1));
		send_request(make_request(OP_LOAD, 2, 4, 16'h0004, 0, '0));
		send_request(make_request(OP_DRAW, 2, 0, 0, 0, 31'h0000_1234));
	endtask

	task automatic test_draw_boundaries();
		send_request(make_request(OP_LOAD, 0, 0, 16'h0000, 0, '0));
		send_request(make_request(OP_LOAD, 0, 15, 16'hFFFF, 16'hFFFF, '1));
		send_request(make_request(OP_LOAD, 0, 5, 16'h1234, 1, '0));
		send_request(make_request(OP_LOAD, 0, 10, 16'hABCD, 0, '0));
		send_request(make_request(OP_DRAW, 0, 0, 0, 0, '0));
		send_request(make_request(OP_DRAW, 0, 0, 0, 0, 31'd65535));
		send_request(make_request(OP_DRAW, 0, 0, 0, 0, 31'd65536));
		send_request(make_request(OP_DRAW, 0, 0, 0, 0, '1));
		send_request(make_request(OP_LOAD, 15, 9, 16'h5A5A, 16'hFFFF, '0));
		send_request(make_request(OP_DRAW, 15, 0, 0, 0, '1));
	endtask

	task automatic test_full_list();
		send_request(make_request(OP_LOAD, 0, 1, 16'h0101, 2, '0));
		send_request(make_request(OP_LOAD, 0, 2, 16'h0202, 16'h8000, '0));
		send_request(make_request(OP_LOAD, 0, 3, 16'h0303, 0, '0));
		send_request(make_request(OP_LOAD, 0, 4, 16'h0404, 7, '0));
		send_request(make_request(OP_LOAD, 0, 6, 16'h0606, 9, '1));
		send_request(make_request(OP_DRAW, 0, 0, 0, 0, 31'd65537));
		send_request(make_request(OP_DRAW, 0, 0, 0, 0, '1));
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int count);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count) send_request(random_request());
	endtask

	// response side held off while requests keep coming
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_requested = 1'b1;
		repeat (16) send_request(random_request());
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 17;
		rsp_stall_pct = 17;
		repeat (3) begin
			req_ch.valid <= 1'b0;
			while (awaited_outcomes.size() != 0) @(posedge clk);
			repeat (10) send_request(random_request());
		end
	endtask

	// response ready
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				hold_left = HOLD_CYCLES;
				hold_requested = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// response check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected response: status %0d kind %0d code %h",
							rsp_ch.data.status, rsp_ch.data.drawn_kind,
							rsp_ch.data.drawn_code);
				end else begin
					if (rsp_ch.data.status !== awaited_outcomes[0].status
							|| rsp_ch.data.drawn_kind !== awaited_outcomes[0].drawn_kind
							|| rsp_ch.data.drawn_code !== awaited_outcomes[0].drawn_code) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected status %0d kind %0d code %h, got status %0d kind %0d code %h",
								awaited_outcomes[0].status, awaited_outcomes[0].drawn_kind,
								awaited_outcomes[0].drawn_code, rsp_ch.data.status,
								rsp_ch.data.drawn_kind, rsp_ch.data.drawn_code);
					end
					void'(awaited_outcomes.pop_front());
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL weighted_random_table_draw");
				$finish;
			end
		end
	end

	initial begin
		for (int g = 0; g < NUM_GROUPS; g++)
			shadow_fill[g] = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_group();
		test_draw_boundaries();
		test_full_list();
		test_random_traffic(0, 0, 360);
		test_random_traffic(64, 0, 360);
		test_random_traffic(0, 64, 360);
		test_random_traffic(17, 17, 360);
		test_backpressure_fill();
		test_drain_pause();
		req_ch.valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_outcomes.size() == 0)
			$display("PASS weighted_random_table_draw");
		else
			$display("FAIL weighted_random_table_draw");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/wrtd_pkg.sv
design/wrtd_req_if.sv
design/wrtd_rsp_if.sv
design/weighted_random_table_draw.sv
tb/tb_weighted_random_table_draw.sv
